// File: design/vafzp_pkg.sv
// Package for the one-axis FIR pass of a separable 3D convolution.
// Holds the sizes, command and register codes, the controller state type and
// the clamping helpers. It depends on nothing else.
package vafzp_pkg;

  localparam int MAX_X      = 64;
  localparam int MAX_Y      = 64;
  localparam int MAX_Z      = 64;
  localparam int MAX_TAPS   = 15;
  localparam int RING_DEPTH = 65536;

  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 4;
  localparam int SIZE_W    = 7;
  localparam int COORD_W   = 6;
  localparam int TAP_W     = 4;
  localparam int CENTRE_W  = 3;
  localparam int RING_AW   = $clog2(RING_DEPTH);
  localparam int STRIDE_W  = $clog2(MAX_X * MAX_Y + 1);
  localparam int CNT_W     = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 15;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_DRAIN  = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_OFFS,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [TAP_W-1:0] clamp_taps(input logic [TAP_W-1:0] v);
    logic [TAP_W-1:0] r;
    if (v == '0) begin
      r = TAP_W'(1);
    end else if (v > TAP_W'(MAX_TAPS)) begin
      r = TAP_W'(MAX_TAPS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/volume_axis_fir_zero_pad_core.sv
// Top level of the one-axis FIR pass of a separable 3D convolution.
// Holds the sample ring memory, tap registers, controller and output register.
// It depends on vafzp_pkg.

// Samples are stored in a ring memory with one read port; each output reads one ring word
// per tap and accumulates one product per tap that falls inside the volume. An item that
// yields an output holds the controller until its result is loaded, which waits while an
// earlier result is held in the output register by a stall. Items with no output return to
// idle after ST_OFFS and ST_CHECK; coefficient loads are taken in idle. A configuration write
// is followed by ST_SETUP1 and ST_SETUP2, where the derived volume sizes settle and no beat is
// taken. The output register lets the next beat be accepted while a result waits to be taken.
module volume_axis_fir_zero_pad_core import vafzp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic signed [DATA_W-1:0]    in_sample,
  input  logic [TAP_W-1:0]            in_coeff_index,
  input  logic signed [DATA_W-1:0]    in_coeff_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_W-1:0]    out_sample,
  output logic                        out_saturated,
  output logic                        out_last_of_volume,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SIZE_W-1:0]           cfg_data
);

  state_t state_r, state_nxt;

  logic [1:0]           axis_r;
  logic [SIZE_W-1:0]    size_x_r, size_y_r, size_z_r;
  logic [TAP_W-1:0]     taps_r;
  logic [STRIDE_W-1:0]  sxy_r;
  logic [CNT_W-1:0]     total_r;

  logic signed [DATA_W-1:0] weight_r [MAX_TAPS];

  logic [CNT_W-1:0]     inputs_seen_r, outputs_sent_r;
  logic [COORD_W-1:0]   coord_x_r, coord_y_r, coord_z_r;

  logic signed [DATA_W-1:0] ring_mem [RING_DEPTH];
  logic signed [DATA_W-1:0] ring_q_r;

  logic [RING_AW-1:0]   offset_r, addr_r;
  logic signed [7:0]    n_r;
  logic [TAP_W-1:0]     m_r;
  logic                 v1_r, v2_r;
  logic signed [DATA_W-1:0] w1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_sample_r;
  logic                     out_sat_r, out_last_r;

  logic in_acc, cfg_acc, cfg_hit, out_load, ring_we, is_item, ready;
  logic [TAP_W-1:0]     tap_m1;
  logic [CENTRE_W-1:0]  centre, ahead, ahead_eff;
  logic [COORD_W-1:0]   cur_c;
  logic [SIZE_W-1:0]    cur_s, room;
  logic [STRIDE_W-1:0]  cur_st;
  logic [RING_AW-1:0]   st_ext, ahead_ext, centre_ext;
  logic [CNT_W:0]       need_cnt;
  logic                 last_out, in_range;
  logic [SIZE_W-1:0]    x_inc, y_inc;
  logic                 sat_hi, sat_lo;
  logic signed [DATA_W-1:0] q_sat;

  assign in_acc  = in_valid && !in_stall;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign cfg_hit = cfg_acc && (cfg_index == CFG_AXIS || cfg_index == CFG_SIZE_X ||
                   cfg_index == CFG_SIZE_Y || cfg_index == CFG_SIZE_Z || cfg_index == CFG_TAPS);
  assign is_item = in_command == CMD_SAMPLE || in_command == CMD_DRAIN;
  assign ring_we = in_acc && in_command == CMD_SAMPLE && inputs_seen_r < total_r;

  assign tap_m1    = taps_r - TAP_W'(1);
  assign centre    = tap_m1[TAP_W-1:1];
  assign ahead     = CENTRE_W'(tap_m1 - {1'b0, centre});

  always_comb begin
    case (axis_r)
      AXIS_Y: begin
        cur_c  = coord_y_r;
        cur_s  = size_y_r;
        cur_st = STRIDE_W'(size_x_r);
      end
      AXIS_Z: begin
        cur_c  = coord_z_r;
        cur_s  = size_z_r;
        cur_st = sxy_r;
      end
      default: begin
        cur_c  = coord_x_r;
        cur_s  = size_x_r;
        cur_st = STRIDE_W'(1);
      end
    endcase
  end

  assign room       = cur_s - SIZE_W'(1) - {1'b0, cur_c};
  assign ahead_eff  = (room < SIZE_W'(ahead)) ? room[CENTRE_W-1:0] : ahead;
  assign st_ext     = RING_AW'(cur_st);
  assign ahead_ext  = RING_AW'(ahead_eff);
  assign centre_ext = RING_AW'(centre);
  assign need_cnt   = {1'b0, outputs_sent_r} + (CNT_W+1)'(offset_r);
  assign ready      = outputs_sent_r < total_r && {1'b0, inputs_seen_r} > need_cnt;
  assign in_range   = !n_r[7] && n_r[SIZE_W-1:0] < cur_s;
  assign last_out   = outputs_sent_r + CNT_W'(1) == total_r;
  assign x_inc      = {1'b0, coord_x_r} + SIZE_W'(1);
  assign y_inc      = {1'b0, coord_y_r} + SIZE_W'(1);

  assign sat_hi = !acc_r[ACC_W-1] && acc_r[ACC_W-2:FRAC_W+DATA_W-1] != '0;
  assign sat_lo = acc_r[ACC_W-1] && acc_r[ACC_W-2:FRAC_W+DATA_W-1] != '1;

  always_comb begin
    if (sat_hi) begin
      q_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sat_lo) begin
      q_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      q_sat = acc_r[FRAC_W+DATA_W-1:FRAC_W];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          state_nxt = ST_SETUP1;
        end else if (in_acc && is_item) begin
          state_nxt = ST_OFFS;
        end
      end
      ST_SETUP1: state_nxt = ST_SETUP2;
      ST_SETUP2: state_nxt = ST_IDLE;
      ST_OFFS:   state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ready ? ST_MAC : ST_IDLE;
      ST_MAC: begin
        if (m_r == tap_m1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != ST_IDLE || cfg_valid;
    cfg_ready = state_r == ST_IDLE;
    out_load  = state_r == ST_FIN && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= AXIS_X;
      size_x_r <= SIZE_W'(MAX_X);
      size_y_r <= SIZE_W'(MAX_Y);
      size_z_r <= SIZE_W'(MAX_Z);
      taps_r   <= TAP_W'(1);
      sxy_r    <= STRIDE_W'(MAX_X * MAX_Y);
      total_r  <= CNT_W'(MAX_X * MAX_Y * MAX_Z);
    end else begin
      sxy_r   <= STRIDE_W'(size_x_r) * STRIDE_W'(size_y_r);
      total_r <= CNT_W'(sxy_r) * CNT_W'(size_z_r);
      if (cfg_acc) begin
        case (cfg_index)
          CFG_AXIS:   axis_r   <= cfg_data[1:0];
          CFG_SIZE_X: size_x_r <= clamp_size(cfg_data, SIZE_W'(MAX_X));
          CFG_SIZE_Y: size_y_r <= clamp_size(cfg_data, SIZE_W'(MAX_Y));
          CFG_SIZE_Z: size_z_r <= clamp_size(cfg_data, SIZE_W'(MAX_Z));
          CFG_TAPS:   taps_r   <= clamp_taps(cfg_data[TAP_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        weight_r[i] <= '0;
      end
    end else if (in_acc && in_command == CMD_LOAD && in_coeff_index < TAP_W'(MAX_TAPS)) begin
      weight_r[in_coeff_index] <= in_coeff_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inputs_seen_r  <= '0;
      outputs_sent_r <= '0;
      coord_x_r      <= '0;
      coord_y_r      <= '0;
      coord_z_r      <= '0;
    end else if (cfg_hit || (out_load && last_out)) begin
      inputs_seen_r  <= '0;
      outputs_sent_r <= '0;
      coord_x_r      <= '0;
      coord_y_r      <= '0;
      coord_z_r      <= '0;
    end else begin
      if (ring_we) begin
        inputs_seen_r <= inputs_seen_r + CNT_W'(1);
      end
      if (out_load) begin
        outputs_sent_r <= outputs_sent_r + CNT_W'(1);
        if (x_inc >= size_x_r) begin
          coord_x_r <= '0;
          if (y_inc >= size_y_r) begin
            coord_y_r <= '0;
            coord_z_r <= coord_z_r + COORD_W'(1);
          end else begin
            coord_y_r <= y_inc[COORD_W-1:0];
          end
        end else begin
          coord_x_r <= x_inc[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[inputs_seen_r[RING_AW-1:0]] <= in_sample;
    end
    ring_q_r <= ring_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OFFS) begin
      offset_r <= RING_AW'(ahead_ext * st_ext);
      addr_r   <= outputs_sent_r[RING_AW-1:0] - RING_AW'(centre_ext * st_ext);
      n_r      <= $signed({2'b00, cur_c}) - $signed({5'b00000, centre});
      m_r      <= '0;
    end else if (state_r == ST_MAC) begin
      addr_r <= addr_r + st_ext;
      n_r    <= n_r + 8'sd1;
      m_r    <= m_r + TAP_W'(1);
    end
    w1_r   <= weight_r[m_r];
    prod_r <= ring_q_r * w1_r;
    if (state_r == ST_CHECK) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= state_r == ST_MAC && in_range;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= q_sat;
      out_sat_r    <= sat_hi || sat_lo;
      out_last_r   <= last_out;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample         = out_sample_r;
  assign out_saturated      = out_sat_r;
  assign out_last_of_volume = out_last_r;

  a_sent_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    outputs_sent_r < total_r)
    else $error("Output count reached the volume size without a restart.");

  a_fin_has_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> inputs_seen_r > outputs_sent_r)
    else $error("An output was computed ahead of the samples it needs.");

  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !v1_r && !v2_r)
    else $error("Configuration accepted while taps were still in flight.");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("A result beat appeared without a finished accumulation.");

endmodule
